[rtl/core/mma_pkg.sv]
package mma_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned CFG_AW = 2;

  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_LOAD_C  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_COLS_A = 2'd1,
    CFG_COLS_B = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELEM,
    S_MAC,
    S_DRAIN,
    S_EMIT
  } state_t;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // last loop index for a dimension register: zero acts as one, too large saturates
  function automatic logic [CFG_W-1:0] dim_last(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] maxd);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > maxd) begin
      r = maxd - 4'd1;
    end else begin
      r = v - 4'd1;
    end
    return r;
  endfunction

endpackage

[rtl/core/mma_if.sv]
interface mma_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic [mma_pkg::IDX_W-1:0]         row;
  logic [mma_pkg::IDX_W-1:0]         col;
  logic signed [mma_pkg::DATA_W-1:0] value;

  modport source (output valid, output opcode, output row, output col, output value,
                  input ready);
  modport sink (input valid, input opcode, input row, input col, input value,
                output ready);
endinterface

interface mma_out_if;
  logic                              valid;
  logic                              ready;
  logic [mma_pkg::IDX_W-1:0]         out_row;
  logic [mma_pkg::IDX_W-1:0]         out_col;
  logic signed [mma_pkg::DATA_W-1:0] result;
  logic                              last;

  modport source (output valid, output out_row, output out_col, output result,
                  output last, input ready);
  modport sink (input valid, input out_row, input out_col, input result, input last,
                output ready);
endinterface

[rtl/core/matrix_multiply_accumulate.sv]
// integer matrix multiply-accumulate, C += A * B, 32-bit wrapping arithmetic
// in_ch carries items: opcode load A, load B, load C start (row, col, value)
// or compute; a load whose row or col is not below MAX_DIM is dropped
// a load leaves the sequencer idle, and the next item is taken in the following cycle
// a compute item produces rows_a * cols_b items on out_ch, row-major,
// each with row, column and a last mark on the final element
// each result element goes through one accumulator read, one A/B read pair
// per inner step through the single multiplier, a drain of the multiply/add
// pipeline and one write-back and emit
// no new item is taken until the last element sits in the output register
// cfg_we writes rows_a, cols_a, cols_b by index; 0 acts as 1, above MAX_DIM
// acts as MAX_DIM; write only while idle
// reset sets the dimensions to 8, empties the output register and makes every
// C entry read as zero; A and B hold nothing defined until loaded
// when out_ch.ready is low the element waits in the output register and the
// sequencer holds before the next write-back
module matrix_multiply_accumulate #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mma_in_if.sink                     in_ch,
  mma_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [mma_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [mma_pkg::CFG_W-1:0]  cfg_data
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic a_we, b_we, c_we;
  logic [AW-1:0] ld_addr, c_waddr, a_raddr, b_raddr, c_raddr;
  logic [mma_pkg::DATA_W-1:0] ld_data, c_wdata, a_rdata, b_rdata, c_rdata;

  mma_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .a_we    (a_we),
    .b_we    (b_we),
    .c_we    (c_we),
    .ld_addr (ld_addr),
    .ld_data (ld_data),
    .c_waddr (c_waddr),
    .c_wdata (c_wdata),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr),
    .c_raddr (c_raddr),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata),
    .c_rdata (c_rdata)
  );

  mma_ram #(.DEPTH(DEPTH), .WIDTH(mma_pkg::DATA_W)) u_store_a (
    .clk  (clk),
    .we   (a_we),
    .waddr(ld_addr),
    .wdata(ld_data),
    .raddr(a_raddr),
    .rdata(a_rdata)
  );

  mma_ram #(.DEPTH(DEPTH), .WIDTH(mma_pkg::DATA_W)) u_store_b (
    .clk  (clk),
    .we   (b_we),
    .waddr(ld_addr),
    .wdata(ld_data),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  mma_ram #(.DEPTH(DEPTH), .WIDTH(mma_pkg::DATA_W)) u_store_c (
    .clk  (clk),
    .we   (c_we),
    .waddr(c_waddr),
    .wdata(c_wdata),
    .raddr(c_raddr),
    .rdata(c_rdata)
  );

endmodule

[rtl/core/mma_ram.sv]
module mma_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/mma_seq.sv]
module mma_seq #(
  parameter int unsigned MAX_DIM = 8,
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM,
  localparam int unsigned AW     = $clog2(DEPTH),
  localparam int unsigned IW     = $clog2(MAX_DIM)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mma_in_if.sink                      in_ch,
  mma_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [mma_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mma_pkg::CFG_W-1:0]   cfg_data,
  output logic                        a_we,
  output logic                        b_we,
  output logic                        c_we,
  output logic [AW-1:0]               ld_addr,
  output logic [mma_pkg::DATA_W-1:0]  ld_data,
  output logic [AW-1:0]               c_waddr,
  output logic [mma_pkg::DATA_W-1:0]  c_wdata,
  output logic [AW-1:0]               a_raddr,
  output logic [AW-1:0]               b_raddr,
  output logic [AW-1:0]               c_raddr,
  input  logic [mma_pkg::DATA_W-1:0]  a_rdata,
  input  logic [mma_pkg::DATA_W-1:0]  b_rdata,
  input  logic [mma_pkg::DATA_W-1:0]  c_rdata
);

  localparam logic [mma_pkg::CFG_W-1:0] MAXD = mma_pkg::CFG_W'(MAX_DIM);

  mma_pkg::state_t state_r, state_nxt;

  logic [mma_pkg::CFG_W-1:0] rows_a_r, cols_a_r, cols_b_r;
  logic [IW-1:0] nr_last_r, nk_last_r, nc_last_r;
  logic [IW-1:0] i_r, j_r, k_r;
  logic          rd_v_r, prod_v_r;
  logic [mma_pkg::DATA_W-1:0] prod_r, acc_r;
  logic [DEPTH-1:0] c_valid_r;
  logic          c_vld_q_r;
  logic          c_load_r;
  logic          out_valid_r;
  logic [mma_pkg::IDX_W-1:0]  out_row_r, out_col_r;
  logic [mma_pkg::DATA_W-1:0] out_result_r;
  logic          out_last_r;

  logic in_fire, ld_ok, start, mac_issue, emit_fire, elem_last;
  mma_pkg::op_t op;

  assign op        = mma_pkg::op_t'(in_ch.opcode);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign ld_ok     = (int'(in_ch.row) < MAX_DIM) && (int'(in_ch.col) < MAX_DIM);
  assign start     = in_fire && (op == mma_pkg::OP_COMPUTE);
  assign mac_issue = (state_r == mma_pkg::S_MAC);
  assign elem_last = (i_r == nr_last_r) && (j_r == nc_last_r);
  assign emit_fire = (state_r == mma_pkg::S_EMIT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = (state_r == mma_pkg::S_IDLE);

  assign ld_addr = AW'(int'(in_ch.row) * MAX_DIM + int'(in_ch.col));
  assign ld_data = in_ch.value;
  assign a_we    = in_fire && ld_ok && (op == mma_pkg::OP_LOAD_A);
  assign b_we    = in_fire && ld_ok && (op == mma_pkg::OP_LOAD_B);
  assign c_we    = (in_fire && ld_ok && (op == mma_pkg::OP_LOAD_C)) || emit_fire;
  assign c_waddr = emit_fire ? c_raddr : ld_addr;
  assign c_wdata = emit_fire ? acc_r : in_ch.value;

  assign a_raddr = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_raddr = AW'(int'(k_r) * MAX_DIM + int'(j_r));
  assign c_raddr = AW'(int'(i_r) * MAX_DIM + int'(j_r));

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= mma_pkg::DIM_RESET;
      cols_a_r <= mma_pkg::DIM_RESET;
      cols_b_r <= mma_pkg::DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        mma_pkg::CFG_ROWS_A: rows_a_r <= cfg_data;
        mma_pkg::CFG_COLS_A: cols_a_r <= cfg_data;
        mma_pkg::CFG_COLS_B: cols_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mma_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mma_pkg::S_IDLE: begin
        if (start) state_nxt = mma_pkg::S_ELEM;
      end
      mma_pkg::S_ELEM: state_nxt = mma_pkg::S_MAC;
      mma_pkg::S_MAC: begin
        if (k_r == nk_last_r) state_nxt = mma_pkg::S_DRAIN;
      end
      mma_pkg::S_DRAIN: begin
        if (!rd_v_r && !prod_v_r) state_nxt = mma_pkg::S_EMIT;
      end
      mma_pkg::S_EMIT: begin
        if (emit_fire) state_nxt = elem_last ? mma_pkg::S_IDLE : mma_pkg::S_ELEM;
      end
      default: state_nxt = mma_pkg::S_IDLE;
    endcase
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (start) begin
      nr_last_r <= IW'(mma_pkg::dim_last(rows_a_r, MAXD));
      nk_last_r <= IW'(mma_pkg::dim_last(cols_a_r, MAXD));
      nc_last_r <= IW'(mma_pkg::dim_last(cols_b_r, MAXD));
      i_r       <= '0;
      j_r       <= '0;
    end else if (emit_fire) begin
      if (j_r == nc_last_r) begin
        j_r <= '0;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
    if (state_r == mma_pkg::S_ELEM) begin
      k_r <= '0;
    end else if (mac_issue) begin
      k_r <= k_r + 1'b1;
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      c_load_r <= 1'b0;
    end else begin
      rd_v_r   <= mac_issue;
      prod_v_r <= rd_v_r;
      c_load_r <= (state_r == mma_pkg::S_ELEM);
    end
  end

  always_ff @(posedge clk) begin
    c_vld_q_r <= c_valid_r[c_raddr];
    prod_r    <= a_rdata * b_rdata;
    if (c_load_r) begin
      acc_r <= c_vld_q_r ? c_rdata : '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  // accumulator entries read as zero until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= '0;
    end else if (c_we) begin
      c_valid_r[c_waddr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row_r    <= mma_pkg::IDX_W'(i_r);
      out_col_r    <= mma_pkg::IDX_W'(j_r);
      out_result_r <= acc_r;
      out_last_r   <= elem_last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_row = out_row_r;
  assign out_ch.out_col = out_col_r;
  assign out_ch.result  = out_result_r;
  assign out_ch.last    = out_last_r;

endmodule

[rtl/core/mma_checker.sv]
module mma_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [mma_pkg::IDX_W-1:0]  out_row,
  input logic [mma_pkg::IDX_W-1:0]  out_col,
  input logic [mma_pkg::DATA_W-1:0] out_result,
  input logic       out_last
);

  // output register empties at reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled item holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
      && $stable(out_result) && $stable(out_last))
    else $error("stalled output item changed");

  // a compute item closes the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == mma_pkg::OP_COMPUTE) |=> !in_ready)
    else $error("input taken right after compute");

  // no input while a non-final element is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready in the middle of a compute");

endmodule

bind matrix_multiply_accumulate mma_checker u_mma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.out_row),
  .out_col   (out_ch.out_col),
  .out_result(out_ch.result),
  .out_last  (out_ch.last)
);

[test/testbench.sv]
module testbench;

  localparam int unsigned DIM = 8;
  localparam int unsigned DIRECTED = 19;
  localparam int unsigned PHASE_ITEMS = 50;
  localparam int unsigned SETTLE = 12;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [mma_pkg::CFG_AW-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [mma_pkg::IDX_W-1:0]  row;
    logic [mma_pkg::IDX_W-1:0]  col;
    logic [mma_pkg::DATA_W-1:0] sum;
    logic                       last;
  } c_elem_t;

  typedef struct {
    mma_pkg::op_t               op;
    logic [mma_pkg::IDX_W-1:0]  row;
    logic [mma_pkg::IDX_W-1:0]  col;
    logic [mma_pkg::DATA_W-1:0] value;
    bit                         known;
    logic [mma_pkg::DATA_W-1:0] sum;
  } script_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [mma_pkg::CFG_AW-1:0] cfg_addr;
  logic [mma_pkg::CFG_W-1:0]  cfg_data;

  mma_in_if  in_ch ();
  mma_out_if out_ch ();

  matrix_multiply_accumulate #(.MAX_DIM(DIM)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  // mirror of the block's stores and dimension registers
  logic [mma_pkg::DATA_W-1:0] a_mem [DIM*DIM];
  logic [mma_pkg::DATA_W-1:0] b_mem [DIM*DIM];
  logic [mma_pkg::DATA_W-1:0] c_mem [DIM*DIM];
  bit                         a_set [DIM*DIM];
  bit                         b_set [DIM*DIM];
  logic [mma_pkg::CFG_W-1:0]  dim_rows;
  logic [mma_pkg::CFG_W-1:0]  dim_inner;
  logic [mma_pkg::CFG_W-1:0]  dim_cols;

  c_elem_t     pending_elems [$];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  script_t script [DIRECTED] = '{
    '{mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 32'h7fffffff, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_B,  3'd0, 3'd0, 32'h7fffffff, 1'b0, 32'h0},
    '{mma_pkg::OP_COMPUTE, 3'd5, 3'd3, 32'hdeadbeef, 1'b1, 32'h1},
    '{mma_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'h0,        1'b1, 32'h2},
    '{mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 32'h80000000, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_B,  3'd0, 3'd0, 32'h80000000, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_C,  3'd0, 3'd0, 32'h80000000, 1'b0, 32'h0},
    '{mma_pkg::OP_COMPUTE, 3'd7, 3'd0, 32'h7fffffff, 1'b1, 32'h80000000},
    '{mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 32'hffffffff, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_B,  3'd0, 3'd0, 32'hffffffff, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_C,  3'd0, 3'd0, 32'hffffffff, 1'b0, 32'h0},
    '{mma_pkg::OP_COMPUTE, 3'd7, 3'd7, 32'hffffffff, 1'b1, 32'h0},
    '{mma_pkg::OP_LOAD_A,  3'd7, 3'd7, 32'h12345678, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_B,  3'd7, 3'd7, 32'hfedcba98, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_C,  3'd7, 3'd7, 32'h0,        1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_A,  3'd0, 3'd0, 32'h7fffffff, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_B,  3'd0, 3'd0, 32'h80000000, 1'b0, 32'h0},
    '{mma_pkg::OP_LOAD_C,  3'd0, 3'd0, 32'h0,        1'b0, 32'h0},
    '{mma_pkg::OP_COMPUTE, 3'd0, 3'd0, 32'h0,        1'b1, 32'h80000000}
  };

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned eff_dim(input logic [mma_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (32'(v) > DIM) return DIM;
    return 32'(v);
  endfunction

  function automatic logic [mma_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  // update the mirror for one accepted item and queue the C elements it yields
  task automatic apply_item(input mma_pkg::op_t op, input logic [mma_pkg::IDX_W-1:0] r,
                            input logic [mma_pkg::IDX_W-1:0] c,
                            input logic [mma_pkg::DATA_W-1:0] v);
    int unsigned i, j, k, nr, nk, nc, addr;
    logic [mma_pkg::DATA_W-1:0] acc;
    c_elem_t e;
    if (op != mma_pkg::OP_COMPUTE) begin
      if (32'(r) < DIM && 32'(c) < DIM) begin
        addr = 32'(r) * DIM + 32'(c);
        case (op)
          mma_pkg::OP_LOAD_A: begin
            a_mem[addr] = v;
            a_set[addr] = 1'b1;
          end
          mma_pkg::OP_LOAD_B: begin
            b_mem[addr] = v;
            b_set[addr] = 1'b1;
          end
          default: c_mem[addr] = v;
        endcase
      end
    end else begin
      nr = eff_dim(dim_rows);
      nk = eff_dim(dim_inner);
      nc = eff_dim(dim_cols);
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          acc = c_mem[i*DIM+j];
          for (k = 0; k < nk; k++)
            acc = acc + a_mem[i*DIM+k] * b_mem[k*DIM+j];
          c_mem[i*DIM+j] = acc;
          e.row = mma_pkg::IDX_W'(i);
          e.col = mma_pkg::IDX_W'(j);
          e.sum = acc;
          e.last = (i == nr - 1) && (j == nc - 1);
          pending_elems.push_back(e);
        end
      end
    end
  endtask

  task automatic send_item(input mma_pkg::op_t op, input logic [mma_pkg::IDX_W-1:0] r,
                           input logic [mma_pkg::IDX_W-1:0] c,
                           input logic [mma_pkg::DATA_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.row    <= r;
    in_ch.col    <= c;
    in_ch.value  <= v;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(op, r, c, v);
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_elems.size() != 0) @(negedge clk);
  endtask

  task automatic configure(input logic [mma_pkg::CFG_W-1:0] r,
                           input logic [mma_pkg::CFG_W-1:0] k,
                           input logic [mma_pkg::CFG_W-1:0] c, input bit poke_unused);
    logic [mma_pkg::CFG_AW-1:0] idx [4];
    logic [mma_pkg::CFG_W-1:0]  dat [4];
    int unsigned n, cnt;
    wait_results();
    repeat (SETTLE) @(negedge clk);
    idx = '{mma_pkg::CFG_ROWS_A, mma_pkg::CFG_COLS_A, mma_pkg::CFG_COLS_B, CFG_UNUSED};
    dat = '{r, k, c, mma_pkg::CFG_W'($urandom)};
    cnt = poke_unused ? 4 : 3;
    for (n = 0; n < cnt; n++) begin
      cfg_we   <= 1'b1;
      cfg_addr <= idx[n];
      cfg_data <= dat[n];
      @(posedge clk);
      case (idx[n])
        mma_pkg::CFG_ROWS_A: dim_rows = dat[n];
        mma_pkg::CFG_COLS_A: dim_inner = dat[n];
        mma_pkg::CFG_COLS_B: dim_cols = dat[n];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // load every A and B entry the next compute reads that was never written
  task automatic fill_missing();
    int unsigned i, k, nr, nk, nc;
    nr = eff_dim(dim_rows);
    nk = eff_dim(dim_inner);
    nc = eff_dim(dim_cols);
    for (i = 0; i < nr; i++)
      for (k = 0; k < nk; k++)
        if (!a_set[i*DIM+k])
          send_item(mma_pkg::OP_LOAD_A, mma_pkg::IDX_W'(i), mma_pkg::IDX_W'(k),
                    rand_word());
    for (k = 0; k < nk; k++)
      for (i = 0; i < nc; i++)
        if (!b_set[k*DIM+i])
          send_item(mma_pkg::OP_LOAD_B, mma_pkg::IDX_W'(k), mma_pkg::IDX_W'(i),
                    rand_word());
  endtask

  task automatic random_item();
    logic [mma_pkg::IDX_W-1:0] r, c;
    r = mma_pkg::IDX_W'($urandom);
    c = mma_pkg::IDX_W'($urandom);
    if ($urandom_range(99) < 10) begin
      fill_missing();
      send_item(mma_pkg::OP_COMPUTE, r, c, rand_word());
      if ($urandom_range(3) == 0) wait_results();
    end else begin
      send_item(mma_pkg::op_t'($urandom_range(2)), r, c, rand_word());
    end
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    c_elem_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_elems.size() == 0) begin
        $error("result item with none expected: out_row %0d out_col %0d result %0h",
               out_ch.out_row, out_ch.out_col, out_ch.result);
        errors++;
      end else begin
        want = pending_elems.pop_front();
        if (out_ch.out_row !== want.row) begin
          $error("out_row expected %0d actual %0d", want.row, out_ch.out_row);
          errors++;
        end
        if (out_ch.out_col !== want.col) begin
          $error("out_col expected %0d actual %0d", want.col, out_ch.out_col);
          errors++;
        end
        if (out_ch.result !== want.sum) begin
          $error("result expected %0h actual %0h", want.sum, out_ch.result);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last expected %0b actual %0b", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned ph, n, s;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = mma_pkg::CFG_ROWS_A;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = mma_pkg::OP_LOAD_A;
    in_ch.row    = '0;
    in_ch.col    = '0;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    dim_rows     = mma_pkg::DIM_RESET;
    dim_inner    = mma_pkg::DIM_RESET;
    dim_cols     = mma_pkg::DIM_RESET;
    for (s = 0; s < DIM * DIM; s++) begin
      c_mem[s] = '0;
      a_set[s] = 1'b0;
      b_set[s] = 1'b0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part at the smallest dimensions
    configure(4'd0, 4'd0, 4'd0, 1'b1);
    for (s = 0; s < DIRECTED; s++) begin
      send_item(script[s].op, script[s].row, script[s].col, script[s].value);
      if (script[s].known) pending_elems[pending_elems.size()-1].sum = script[s].sum;
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          configure(4'd15, 4'd0, 4'd15, 1'b0);
        end
        1: begin
          send_idle_pct = 63;
          recv_stall_pct = 0;
          configure(mma_pkg::CFG_W'($urandom_range(1, DIM)),
                    mma_pkg::CFG_W'($urandom_range(1, DIM)),
                    mma_pkg::CFG_W'($urandom_range(1, DIM)), 1'b0);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 63;
          configure(4'd8, 4'd8, 4'd8, 1'b1);
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
          configure(mma_pkg::CFG_W'($urandom_range(15)),
                    mma_pkg::CFG_W'($urandom_range(15)),
                    mma_pkg::CFG_W'($urandom_range(15)), 1'b0);
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) random_item();
    end

    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_elems.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mma_pkg.sv
rtl/core/mma_if.sv
rtl/core/mma_ram.sv
rtl/core/mma_seq.sv
rtl/core/matrix_multiply_accumulate.sv
rtl/core/mma_checker.sv
test/testbench.sv
